[hdl/cft_pkg.sv]
// Shared types and constants for the CSV field tokenizer.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package cft_pkg;

  localparam int unsigned HELD_WS_DEPTH_DEF = 32;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_DELIMITER   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_QUOTE_CHAR  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ESCAPE_CHAR = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRIM_WS     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALLOW_EMPTY = 3'd4;

  localparam logic [BYTE_W-1:0] DELIM_RESET  = 8'd44;
  localparam logic [BYTE_W-1:0] QUOTE_RESET  = 8'd34;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd34;

  localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'd9;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'd32;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_ROW_START   = 3'd0,
    MODE_FIELD_START = 3'd1,
    MODE_UNQUOTED    = 3'd2,
    MODE_QUOTED      = 3'd3,
    MODE_AFTER_QUOTE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RELEASE = 2'd1,
    ST_TAIL0   = 2'd2,
    ST_TAIL1   = 2'd3
  } ctl_state_t;

  typedef struct packed {
    logic decode;
    logic emit_rel;
    logic emit_tail0;
    logic emit_tail1;
  } ctl_cmd_t;

  typedef struct packed {
    logic       plan_rel;
    logic [1:0] plan_tails;
    logic       rel_last;
    logic [1:0] tail_cnt;
    logic       out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[hdl/cft_ctrl.sv]
// Sequencing controller of the CSV field tokenizer.
// Depends on cft_pkg; drives commands into cft_datapath and reads its status.
`default_nettype none

module cft_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cft_pkg::dp_status_t stat,
  output cft_pkg::ctl_cmd_t   cmd
);
  import cft_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.decode = 1'b1;
          if (stat.plan_rel) begin
            state_nxt = ST_RELEASE;
          end else if (stat.plan_tails != 2'd0) begin
            state_nxt = ST_TAIL0;
          end
        end
      end
      ST_RELEASE: begin
        if (stat.out_free) begin
          cmd.emit_rel = 1'b1;
          if (stat.rel_last) begin
            state_nxt = (stat.tail_cnt != 2'd0) ? ST_TAIL0 : ST_IDLE;
          end
        end
      end
      ST_TAIL0: begin
        if (stat.out_free) begin
          cmd.emit_tail0 = 1'b1;
          state_nxt = (stat.tail_cnt == 2'd2) ? ST_TAIL1 : ST_IDLE;
        end
      end
      ST_TAIL1: begin
        if (stat.out_free) begin
          cmd.emit_tail1 = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/cft_datapath.sv]
// Datapath of the CSV field tokenizer: configuration, parse state, held
// whitespace store, per-item result plan and the output register. Depends on cft_pkg.
`default_nettype none

module cft_datapath #(
  parameter int unsigned HELD_WS_DEPTH = cft_pkg::HELD_WS_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cft_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [cft_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [cft_pkg::BYTE_W-1:0]     in_byte,
  input  logic                           in_end,
  input  cft_pkg::ctl_cmd_t              cmd,
  output cft_pkg::dp_status_t            stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cft_pkg::kind_t                 out_kind,
  output logic [cft_pkg::BYTE_W-1:0]     out_data,
  output logic                           out_row_empty,
  output logic                           out_trim_ovf,
  output logic                           out_last
);
  import cft_pkg::*;

  localparam int unsigned HC_W  = $clog2(HELD_WS_DEPTH + 1);
  localparam int unsigned IDX_W = (HELD_WS_DEPTH > 1) ? $clog2(HELD_WS_DEPTH) : 1;
  localparam logic [HC_W-1:0] DEPTH_C = HC_W'(HELD_WS_DEPTH);
  localparam logic [HC_W-1:0] HC_ONE  = HC_W'(1);

  // Configuration registers.
  logic [BYTE_W-1:0] delim_r, quote_r, esc_char_r;
  logic              trim_r, allow_r;

  // Parse state.
  mode_t             mode_r;
  logic              esc_held_r, swallow_r, rae_r, fhd_r;
  logic [HC_W-1:0]   hc_r, hc_nxt;
  logic [HELD_WS_DEPTH-1:0] held_r, held_nxt;

  // Plan of the current item.
  logic              rel_ovf_r, push_pend_r, push_bit_r;
  logic [1:0]        tail_cnt_r;
  kind_t             tail_kind_r  [0:1];
  logic [BYTE_W-1:0] tail_data_r  [0:1];
  logic              tail_empty_r [0:1];

  // Output register.
  logic              out_valid_r, out_empty_r, out_ovf_r, out_last_r;
  kind_t             out_kind_r;
  logic [BYTE_W-1:0] out_data_r;

  // Decode variables.
  mode_t             mode_v;
  logic              esc_v, swl_v, rae_v, fhd_v;
  logic [HC_W-1:0]   hc_v;
  logic [1:0]        t_cnt;
  kind_t             t_kind  [0:1];
  logic [BYTE_W-1:0] t_data  [0:1];
  logic              t_empty [0:1];
  logic              rel_v, ovf_v, push_now, push_later, pbit_v;
  logic              do_unq, do_start, do_after, do_qplain;
  logic              is_crlf, is_ws, escq;

  assign is_crlf = (in_byte == CH_CR) || (in_byte == CH_LF);
  assign is_ws   = in_byte inside {CH_SP, CH_TAB};
  assign escq    = (esc_char_r == quote_r);

  // Works out, in one pass, the state after the item and the results it causes.
  always_comb begin
    mode_v     = mode_r;
    esc_v      = esc_held_r;
    swl_v      = swallow_r;
    rae_v      = rae_r;
    fhd_v      = fhd_r;
    hc_v       = hc_r;
    t_cnt      = 2'd0;
    t_kind[0]  = KIND_DATA;
    t_kind[1]  = KIND_DATA;
    t_data[0]  = '0;
    t_data[1]  = '0;
    t_empty[0] = 1'b0;
    t_empty[1] = 1'b0;
    rel_v      = 1'b0;
    ovf_v      = 1'b0;
    push_now   = 1'b0;
    push_later = 1'b0;
    pbit_v     = (in_byte == CH_TAB);
    do_unq     = 1'b0;
    do_start   = 1'b0;
    do_after   = 1'b0;
    do_qplain  = 1'b0;

    if (in_end) begin
      case (mode_r)
        MODE_FIELD_START: begin
          t_kind[t_cnt[0]]  = KIND_ROW_END;
          t_empty[t_cnt[0]] = rae_v && !allow_r;
          t_cnt = t_cnt + 2'd1;
        end
        MODE_UNQUOTED, MODE_AFTER_QUOTE: begin
          t_kind[t_cnt[0]] = KIND_FIELD_END;
          t_cnt = t_cnt + 2'd1;
          rae_v = rae_v && !fhd_v;
          t_kind[t_cnt[0]]  = KIND_ROW_END;
          t_empty[t_cnt[0]] = rae_v && !allow_r;
          t_cnt = t_cnt + 2'd1;
        end
        MODE_QUOTED: begin
          if (esc_held_r && escq) begin
            t_kind[t_cnt[0]] = KIND_FIELD_END;
            t_cnt = t_cnt + 2'd1;
            rae_v = rae_v && !fhd_v;
            t_kind[t_cnt[0]]  = KIND_ROW_END;
            t_empty[t_cnt[0]] = rae_v && !allow_r;
            t_cnt = t_cnt + 2'd1;
          end else begin
            if (esc_held_r) begin
              t_data[t_cnt[0]] = esc_char_r;
              t_cnt = t_cnt + 2'd1;
            end
            t_kind[t_cnt[0]] = KIND_ERROR;
            t_cnt = t_cnt + 2'd1;
          end
        end
        default: begin
        end
      endcase
      mode_v = MODE_ROW_START;
      esc_v  = 1'b0;
      swl_v  = 1'b0;
      rae_v  = 1'b1;
      fhd_v  = 1'b0;
      hc_v   = '0;
    end else begin
      swl_v = 1'b0;
      if (!(swallow_r && in_byte == CH_LF)) begin
        case (mode_r)
          MODE_UNQUOTED: do_unq = 1'b1;
          MODE_QUOTED: begin
            if (!esc_held_r) begin
              do_qplain = 1'b1;
            end else begin
              esc_v = 1'b0;
              if (in_byte == quote_r) begin
                t_data[t_cnt[0]] = quote_r;
                t_cnt = t_cnt + 2'd1;
                fhd_v = 1'b1;
              end else if (escq) begin
                do_after = 1'b1;
              end else begin
                t_data[t_cnt[0]] = esc_char_r;
                t_cnt = t_cnt + 2'd1;
                fhd_v = 1'b1;
                do_qplain = 1'b1;
              end
            end
          end
          MODE_AFTER_QUOTE: do_after = 1'b1;
          default: do_start = 1'b1;
        endcase

        if (do_qplain) begin
          if (in_byte == esc_char_r) begin
            esc_v = 1'b1;
          end else if (in_byte == quote_r) begin
            mode_v = MODE_AFTER_QUOTE;
          end else begin
            t_data[t_cnt[0]] = in_byte;
            t_cnt = t_cnt + 2'd1;
            fhd_v = 1'b1;
          end
        end

        if (do_after) begin
          t_kind[t_cnt[0]] = KIND_FIELD_END;
          t_cnt = t_cnt + 2'd1;
          hc_v  = '0;
          rae_v = rae_v && !fhd_v;
          fhd_v = 1'b0;
          if (in_byte == delim_r) begin
            mode_v = MODE_FIELD_START;
          end else if (is_crlf) begin
            t_kind[t_cnt[0]]  = KIND_ROW_END;
            t_empty[t_cnt[0]] = rae_v && !allow_r;
            t_cnt  = t_cnt + 2'd1;
            rae_v  = 1'b1;
            mode_v = MODE_ROW_START;
            swl_v  = (in_byte == CH_CR);
          end else begin
            do_start = 1'b1;
          end
        end

        if (do_start) begin
          fhd_v = 1'b0;
          hc_v  = '0;
          if (in_byte == quote_r) begin
            mode_v = MODE_QUOTED;
            esc_v  = 1'b0;
          end else begin
            mode_v = MODE_UNQUOTED;
            do_unq = 1'b1;
          end
        end

        if (do_unq) begin
          if (in_byte == delim_r) begin
            t_kind[t_cnt[0]] = KIND_FIELD_END;
            t_cnt  = t_cnt + 2'd1;
            hc_v   = '0;
            rae_v  = rae_v && !fhd_v;
            fhd_v  = 1'b0;
            mode_v = MODE_FIELD_START;
          end else if (is_crlf) begin
            t_kind[t_cnt[0]] = KIND_FIELD_END;
            t_cnt = t_cnt + 2'd1;
            hc_v  = '0;
            rae_v = rae_v && !fhd_v;
            fhd_v = 1'b0;
            t_kind[t_cnt[0]]  = KIND_ROW_END;
            t_empty[t_cnt[0]] = rae_v && !allow_r;
            t_cnt  = t_cnt + 2'd1;
            rae_v  = 1'b1;
            mode_v = MODE_ROW_START;
            swl_v  = (in_byte == CH_CR);
          end else if (trim_r && is_ws) begin
            if (fhd_v) begin
              if (hc_v >= DEPTH_C) begin
                rel_v      = 1'b1;
                ovf_v      = 1'b1;
                push_later = 1'b1;
              end else begin
                push_now = 1'b1;
              end
            end
          end else begin
            rel_v = (hc_v != '0);
            t_data[t_cnt[0]] = in_byte;
            t_cnt = t_cnt + 2'd1;
            fhd_v = 1'b1;
          end
        end
      end
    end
  end

  // Held whitespace store: appended at the fill level, drained from entry zero.
  always_comb begin
    held_nxt = held_r;
    hc_nxt   = hc_r;
    if (cmd.decode) begin
      if (rel_v) begin
        hc_nxt = hc_r;
      end else if (push_now) begin
        held_nxt[hc_v[IDX_W-1:0]] = pbit_v;
        hc_nxt = hc_v + HC_ONE;
      end else begin
        hc_nxt = hc_v;
      end
    end else if (cmd.emit_rel) begin
      held_nxt = held_r >> 1;
      if (hc_r == HC_ONE) begin
        if (push_pend_r) begin
          held_nxt[0] = push_bit_r;
          hc_nxt = HC_ONE;
        end else begin
          hc_nxt = '0;
        end
      end else begin
        hc_nxt = hc_r - HC_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r    <= DELIM_RESET;
      quote_r    <= QUOTE_RESET;
      esc_char_r <= ESCAPE_RESET;
      trim_r     <= 1'b0;
      allow_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELIMITER:   delim_r    <= cfg_wdata;
        CFG_QUOTE_CHAR:  quote_r    <= cfg_wdata;
        CFG_ESCAPE_CHAR: esc_char_r <= cfg_wdata;
        CFG_TRIM_WS:     trim_r     <= cfg_wdata[0];
        CFG_ALLOW_EMPTY: allow_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_ROW_START;
      esc_held_r  <= 1'b0;
      swallow_r   <= 1'b0;
      rae_r       <= 1'b1;
      fhd_r       <= 1'b0;
      hc_r        <= '0;
      push_pend_r <= 1'b0;
      tail_cnt_r  <= 2'd0;
    end else begin
      hc_r <= hc_nxt;
      if (cmd.decode) begin
        mode_r      <= mode_v;
        esc_held_r  <= esc_v;
        swallow_r   <= swl_v;
        rae_r       <= rae_v;
        fhd_r       <= fhd_v;
        push_pend_r <= push_later;
        tail_cnt_r  <= t_cnt;
      end else if (cmd.emit_rel && hc_r == HC_ONE) begin
        push_pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      rel_ovf_r       <= ovf_v;
      push_bit_r      <= pbit_v;
      tail_kind_r[0]  <= t_kind[0];
      tail_kind_r[1]  <= t_kind[1];
      tail_data_r[0]  <= t_data[0];
      tail_data_r[1]  <= t_data[1];
      tail_empty_r[0] <= t_empty[0];
      tail_empty_r[1] <= t_empty[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_rel || cmd.emit_tail0 || cmd.emit_tail1) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_rel) begin
      out_kind_r  <= KIND_DATA;
      out_data_r  <= held_r[0] ? CH_TAB : CH_SP;
      out_empty_r <= 1'b0;
      out_ovf_r   <= rel_ovf_r;
      out_last_r  <= (hc_r == HC_ONE) && (tail_cnt_r == 2'd0);
    end else if (cmd.emit_tail0) begin
      out_kind_r  <= tail_kind_r[0];
      out_data_r  <= tail_data_r[0];
      out_empty_r <= tail_empty_r[0];
      out_ovf_r   <= 1'b0;
      out_last_r  <= (tail_cnt_r == 2'd1);
    end else if (cmd.emit_tail1) begin
      out_kind_r  <= tail_kind_r[1];
      out_data_r  <= tail_data_r[1];
      out_empty_r <= tail_empty_r[1];
      out_ovf_r   <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  assign stat.plan_rel   = rel_v;
  assign stat.plan_tails = t_cnt;
  assign stat.rel_last   = (hc_r == HC_ONE);
  assign stat.tail_cnt   = tail_cnt_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data      = out_data_r;
  assign out_row_empty = out_empty_r;
  assign out_trim_ovf  = out_ovf_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

[hdl/csv_field_tokenizer_top.sv]
// CSV field tokenizer: one text byte per input transfer, field bytes and markers out.
// The results of an item are loaded one by one into the output register, each waiting while
// the register holds a result not yet accepted; a new item is taken only when all are loaded,
// and released held whitespace counts one result per byte.
// Reset is synchronous, active low; it restores the register defaults and parse state at once.
// Depends on cft_pkg, cft_ctrl and cft_datapath.
`default_nettype none

module csv_field_tokenizer_top #(
  parameter int unsigned HELD_WS_DEPTH = cft_pkg::HELD_WS_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cft_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [cft_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,  // [7:0] text_byte
  input  logic                           in_tlast,  // end_of_input
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata, // [7:0] data_byte, [8] row_empty,
                                                    // [9] trim_overflow, [15:10] zero
  output logic [1:0]                     out_tuser, // [1:0] kind
  output logic                           out_tlast  // last
);
  import cft_pkg::*;

  ctl_cmd_t          cmd;
  dp_status_t        stat;
  kind_t             out_kind;
  logic [BYTE_W-1:0] out_data;
  logic              out_row_empty, out_trim_ovf;

  cft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cft_datapath #(
    .HELD_WS_DEPTH (HELD_WS_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_byte       (in_tdata),
    .in_end        (in_tlast),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_kind      (out_kind),
    .out_data      (out_data),
    .out_row_empty (out_row_empty),
    .out_trim_ovf  (out_trim_ovf),
    .out_last      (out_tlast)
  );

  assign out_tdata = {6'b0, out_trim_ovf, out_row_empty, out_data};
  assign out_tuser = out_kind;

  // An input transfer never coincides with loading a result.
  a_no_emit_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !(cmd.emit_rel || cmd.emit_tail0 || cmd.emit_tail1))
    else $error("result loaded in the cycle of an input transfer");

  // The unclosed quote error always ends the results of its item.
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_ERROR) |-> out_tlast)
    else $error("error result not marked last");

  // The empty-row flag appears only on row ends.
  a_empty_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[8]) |-> (out_tuser == KIND_ROW_END))
    else $error("row_empty set on a result that is not a row end");

  // Early released whitespace is always a data byte.
  a_ovf_on_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[9]) |-> (out_tuser == KIND_DATA))
    else $error("trim_overflow set on a marker");

endmodule

`default_nettype wire

[tb/tb_csv_field_tokenizer_top.sv]
// Self-checking testbench for csv_field_tokenizer_top: a directed table, then random CSV text.
// Result transfers are checked against a predictor of the tokenizer held in this file, or against a hand-written row.
// Depends on cft_pkg and csv_field_tokenizer_top only.
`default_nettype none

module tb_csv_field_tokenizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cft_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned NUM_PHASES  = 7;
  localparam int unsigned PHASE_ITEMS = 24;
  localparam int unsigned SETTLE      = 8;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       row_empty;
    logic       trim_ovf;
    logic       last;
  } token_t;

  typedef enum logic [1:0] {ROW_TEXT, ROW_EOT, ROW_CFG} row_op_t;
  typedef enum logic [1:0] {BY_MODEL, NO_TOKENS, ONE_TOKEN} check_t;

  // For a configuration row, arg is the register index and data the value written.
  typedef struct packed {
    row_op_t    op;
    logic [7:0] arg;
    check_t     check;
    kind_t      kind;
    logic [7:0] data;
  } drow_t;

  typedef struct packed {
    check_t     check;
    kind_t      kind;
    logic [7:0] data;
  } item_plan_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } text_item_t;

  localparam drow_t DIRECTED [32] = '{
    '{ROW_EOT,  8'h00, NO_TOKENS, KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h00, ONE_TOKEN, KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'hFF, ONE_TOKEN, KIND_DATA,  8'hFF},
    '{ROW_TEXT, 8'h2C, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h22, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h78, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h22, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h22, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h22, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h79, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h0D, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h0A, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h0A, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h2C, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_EOT,  8'h00, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h22, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_EOT,  8'h00, ONE_TOKEN, KIND_ERROR, 8'h00},
    '{ROW_CFG,  8'(CFG_ESCAPE_CHAR), BY_MODEL, KIND_DATA, 8'h5C},
    '{ROW_CFG,  8'(CFG_TRIM_WS),     BY_MODEL, KIND_DATA, 8'h01},
    '{ROW_TEXT, 8'h22, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h5C, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h7A, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h22, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h20, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h22, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h20, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h09, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h6B, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h0A, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h22, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_TEXT, 8'h5C, BY_MODEL,  KIND_DATA,  8'h00},
    '{ROW_EOT,  8'h00, BY_MODEL,  KIND_DATA,  8'h00}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  bit          stall_enable = 1'b1;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  token_t     expected_tokens[$];
  token_t     step_tokens[$];
  item_plan_t item_plans[$];
  text_item_t phase_text[$];

  // Predictor copy of the registers and of the parse state.
  logic [7:0]  delim_reg, quote_reg, escape_reg;
  logic        trim_reg, allow_empty_reg;
  mode_t       tk_mode;
  logic        tk_escape_held, tk_swallow_lf, tk_row_all_empty, tk_field_has_data;
  logic        tk_held_is_tab [HELD_WS_DEPTH_DEF];
  int unsigned tk_held_count;

  csv_field_tokenizer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void emit_token(kind_t k, logic [7:0] d, logic empty, logic ovf);
    token_t t;
    t.kind      = k;
    t.data      = d;
    t.row_empty = empty;
    t.trim_ovf  = ovf;
    t.last      = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void take_data(logic [7:0] b);
    emit_token(KIND_DATA, b, 1'b0, 1'b0);
    tk_field_has_data = 1'b1;
  endfunction

  function automatic void flush_held_ws(logic ovf);
    for (int unsigned i = 0; i < tk_held_count; i++)
      emit_token(KIND_DATA, tk_held_is_tab[i] ? CH_TAB : CH_SP, 1'b0, ovf);
    tk_held_count = 0;
  endfunction

  function automatic void end_field();
    emit_token(KIND_FIELD_END, 8'h00, 1'b0, 1'b0);
    tk_held_count = 0;
    if (tk_field_has_data) tk_row_all_empty = 1'b0;
    tk_field_has_data = 1'b0;
  endfunction

  function automatic void end_row();
    emit_token(KIND_ROW_END, 8'h00, tk_row_all_empty && !allow_empty_reg, 1'b0);
    tk_row_all_empty = 1'b1;
    tk_mode = MODE_ROW_START;
  endfunction

  function automatic void clear_parse();
    tk_mode           = MODE_ROW_START;
    tk_escape_held    = 1'b0;
    tk_swallow_lf     = 1'b0;
    tk_row_all_empty  = 1'b1;
    tk_field_has_data = 1'b0;
    tk_held_count     = 0;
  endfunction

  function automatic void unquoted_char(logic [7:0] b);
    if (b == delim_reg) begin
      end_field();
      tk_mode = MODE_FIELD_START;
    end else if (b == CH_CR || b == CH_LF) begin
      end_field();
      end_row();
      tk_swallow_lf = (b == CH_CR);
    end else if (trim_reg && (b == CH_SP || b == CH_TAB)) begin
      // Leading blanks vanish; trailing ones wait for more data in the field.
      if (tk_field_has_data) begin
        if (tk_held_count >= HELD_WS_DEPTH_DEF) flush_held_ws(1'b1);
        tk_held_is_tab[tk_held_count] = (b == CH_TAB);
        tk_held_count++;
      end
    end else begin
      flush_held_ws(1'b0);
      take_data(b);
    end
  endfunction

  function automatic void start_char(logic [7:0] b);
    tk_field_has_data = 1'b0;
    tk_held_count     = 0;
    if (b == quote_reg) begin
      tk_mode        = MODE_QUOTED;
      tk_escape_held = 1'b0;
    end else begin
      tk_mode = MODE_UNQUOTED;
      unquoted_char(b);
    end
  endfunction

  function automatic void after_quote_char(logic [7:0] b);
    if (b == delim_reg) begin
      end_field();
      tk_mode = MODE_FIELD_START;
    end else if (b == CH_CR || b == CH_LF) begin
      end_field();
      end_row();
      tk_swallow_lf = (b == CH_CR);
    end else begin
      end_field();
      start_char(b);
    end
  endfunction

  function automatic void quoted_plain_char(logic [7:0] b);
    if (b == escape_reg) tk_escape_held = 1'b1;
    else if (b == quote_reg) tk_mode = MODE_AFTER_QUOTE;
    else take_data(b);
  endfunction

  function automatic void quoted_char(logic [7:0] b);
    if (!tk_escape_held) begin
      quoted_plain_char(b);
    end else begin
      tk_escape_held = 1'b0;
      if (b == quote_reg) begin
        take_data(quote_reg);
      end else if (escape_reg == quote_reg) begin
        // The held byte was the closing quote after all.
        tk_mode = MODE_AFTER_QUOTE;
        after_quote_char(b);
      end else begin
        take_data(escape_reg);
        quoted_plain_char(b);
      end
    end
  endfunction

  function automatic void end_of_text();
    case (tk_mode)
      MODE_FIELD_START: end_row();
      MODE_UNQUOTED, MODE_AFTER_QUOTE: begin
        end_field();
        end_row();
      end
      MODE_QUOTED: begin
        if (tk_escape_held && escape_reg == quote_reg) begin
          end_field();
          end_row();
        end else begin
          if (tk_escape_held) take_data(escape_reg);
          emit_token(KIND_ERROR, 8'h00, 1'b0, 1'b0);
        end
      end
      default: ;
    endcase
    clear_parse();
  endfunction

  function automatic void tokenize_item(logic [7:0] b, logic eoi);
    logic   swallow;
    token_t t;
    step_tokens.delete();
    if (eoi) begin
      end_of_text();
    end else begin
      swallow       = tk_swallow_lf;
      tk_swallow_lf = 1'b0;
      if (!(swallow && b == CH_LF)) begin
        case (tk_mode)
          MODE_UNQUOTED:    unquoted_char(b);
          MODE_QUOTED:      quoted_char(b);
          MODE_AFTER_QUOTE: after_quote_char(b);
          default:          start_char(b);
        endcase
      end
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.last = 1'b1;
      step_tokens.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : monitor
    token_t     want;
    item_plan_t plan;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d data %02h", out_tuser, out_tdata[7:0]);
          mismatch_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_tuser);
            mismatch_count++;
          end
          if (out_tdata[7:0] !== want.data) begin
            $error("data_byte: expected %02h, got %02h", want.data, out_tdata[7:0]);
            mismatch_count++;
          end
          if (out_tdata[8] !== want.row_empty) begin
            $error("row_empty: expected %0b, got %0b", want.row_empty, out_tdata[8]);
            mismatch_count++;
          end
          if (out_tdata[9] !== want.trim_ovf) begin
            $error("trim_overflow: expected %0b, got %0b", want.trim_ovf, out_tdata[9]);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        plan = item_plans.pop_front();
        tokenize_item(in_tdata, in_tlast);
        // Hand-written rows replace the predicted tokens; the predictor still advances.
        case (plan.check)
          BY_MODEL:  foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
          ONE_TOKEN: expected_tokens.push_back('{plan.kind, plan.data, 1'b0, 1'b0, 1'b1});
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk)
    out_tready <= !stall_enable || ($urandom_range(0, 99) >= 25);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_csv_field_tokenizer_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_text(logic [7:0] b, logic eoi, item_plan_t plan);
    if (stall_enable) begin
      while ($urandom_range(0, 99) < 25) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    item_plans.push_back(plan);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Lets the block settle: an item with no tokens may still be in flight.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0 || item_plans.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DELIMITER:   delim_reg       = val;
      CFG_QUOTE_CHAR:  quote_reg       = val;
      CFG_ESCAPE_CHAR: escape_reg      = val;
      CFG_TRIM_WS:     trim_reg        = val[0];
      CFG_ALLOW_EMPTY: allow_empty_reg = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] d, logic [7:0] q, logic [7:0] e, logic trim,
                            logic allow);
    write_reg(CFG_DELIMITER, d);
    write_reg(CFG_QUOTE_CHAR, q);
    write_reg(CFG_ESCAPE_CHAR, e);
    write_reg(CFG_TRIM_WS, {7'd0, trim});
    write_reg(CFG_ALLOW_EMPTY, {7'd0, allow});
  endtask

  function automatic void push_text(logic [7:0] b, logic eoi);
    text_item_t t;
    t.b   = b;
    t.eoi = eoi;
    phase_text.push_back(t);
  endfunction

  function automatic logic [7:0] any_letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_blank();
    return $urandom_range(0, 1) ? CH_TAB : CH_SP;
  endfunction

  function automatic logic [7:0] unquoted_content();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return any_letter();
    if (r < 72) return any_blank();
    if (r < 80) return quote_reg;
    if (r < 86) return escape_reg;
    return 8'($urandom_range(0, 255));
  endfunction

  // A long blank run inside the field overfills the trailing-blank store.
  function automatic void add_unquoted_field(bit long_run);
    repeat ($urandom_range(0, 2)) push_text(any_blank(), 1'b0);
    push_text(any_letter(), 1'b0);
    repeat ($urandom_range(0, 5)) push_text(unquoted_content(), 1'b0);
    if (long_run) begin
      repeat ($urandom_range(33, 40)) push_text(any_blank(), 1'b0);
      push_text(any_letter(), 1'b0);
    end
    repeat ($urandom_range(0, 2)) push_text(any_blank(), 1'b0);
  endfunction

  function automatic void add_quoted_field();
    push_text(quote_reg, 1'b0);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 7))
        0, 1, 2: push_text(any_letter(), 1'b0);
        3: begin
          push_text(escape_reg, 1'b0);
          push_text(quote_reg, 1'b0);
        end
        4: begin
          push_text(escape_reg, 1'b0);
          push_text(any_letter(), 1'b0);
        end
        5: push_text($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
        6: push_text(delim_reg, 1'b0);
        default: push_text(any_blank(), 1'b0);
      endcase
    end
    push_text(quote_reg, 1'b0);
    if ($urandom_range(0, 7) == 0) push_text(any_letter(), 1'b0);
  endfunction

  function automatic void add_row(bit force_long);
    int unsigned r, nfields;
    r = force_long ? 99 : $urandom_range(0, 99);
    if (r < 12) begin
      // Noise: arbitrary bytes with no structure.
      repeat ($urandom_range(1, 6)) push_text(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 18) begin
      // A quote left open at the end of the text.
      push_text(quote_reg, 1'b0);
      repeat ($urandom_range(0, 3)) push_text(any_letter(), 1'b0);
      if ($urandom_range(0, 1)) push_text(escape_reg, 1'b0);
      push_text(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      nfields = force_long ? 1 : $urandom_range(0, 4);
      for (int unsigned i = 0; i < nfields; i++) begin
        if (i > 0) push_text(delim_reg, 1'b0);
        if (force_long) add_unquoted_field(1'b1);
        else begin
          case ($urandom_range(0, 9))
            0, 1: ;
            2, 3, 4, 5: add_unquoted_field(trim_reg && $urandom_range(0, 11) == 0);
            default: add_quoted_field();
          endcase
        end
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_text(CH_LF, 1'b0);
        4, 5, 6: push_text(CH_CR, 1'b0);
        7, 8: begin
          push_text(CH_CR, 1'b0);
          push_text(CH_LF, 1'b0);
        end
        default: push_text(8'($urandom_range(0, 255)), 1'b1);
      endcase
    end
  endfunction

  function automatic logic [7:0] random_delim();
    case ($urandom_range(0, 5))
      0: return 8'h2C;
      1: return 8'h3B;
      2: return CH_TAB;
      3: return CH_SP;
      4: return 8'h7C;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    drow_t      row;
    item_plan_t plan;
    logic [7:0] q;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    delim_reg       = DELIM_RESET;
    quote_reg       = QUOTE_RESET;
    escape_reg      = ESCAPE_RESET;
    trim_reg        = 1'b0;
    allow_empty_reg = 1'b0;
    clear_parse();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned r = 0; r < $size(DIRECTED); r++) begin
      row = DIRECTED[r];
      if (row.op == ROW_CFG) begin
        wait_drained();
        write_reg(row.arg[CFG_ADDR_W-1:0], row.data);
      end else begin
        plan.check = row.check;
        plan.kind  = row.kind;
        plan.data  = row.data;
        send_text(row.arg, row.op == ROW_EOT, plan);
      end
    end
    wait_drained();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      // One phase runs with both sides flowing freely.
      stall_enable = (p != 3);
      case (p)
        0: set_config(8'h2C, 8'h22, 8'h22, 1'b1, 1'b0);
        1: set_config(8'h00, 8'hFF, 8'hFF, 1'b0, 1'b1);
        2: set_config(8'hFF, 8'h00, 8'h5C, 1'b1, 1'b1);
        3: set_config(8'h3B, 8'h27, 8'h27, 1'b0, 1'b0);
        default: begin
          q = $urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255))
                                        : ($urandom_range(0, 1) ? 8'h22 : 8'h27);
          set_config(random_delim(), q,
                     $urandom_range(0, 1) ? q
                                          : ($urandom_range(0, 1) ? 8'h5C
                                                                  : 8'($urandom_range(0, 255))),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      endcase
      phase_text.delete();
      add_row(p == 0);
      while (phase_text.size() < PHASE_ITEMS) add_row(1'b0);
      push_text(8'($urandom_range(0, 255)), 1'b1);
      plan.check = BY_MODEL;
      plan.kind  = KIND_DATA;
      plan.data  = 8'h00;
      foreach (phase_text[i]) send_text(phase_text[i].b, phase_text[i].eoi, plan);
      wait_drained();
    end

    if (mismatch_count == 0) $display("tb_csv_field_tokenizer_top: PASS");
    else $display("tb_csv_field_tokenizer_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/cft_pkg.sv
hdl/cft_ctrl.sv
hdl/cft_datapath.sv
hdl/csv_field_tokenizer_top.sv
tb/tb_csv_field_tokenizer_top.sv
